### sv/vppt_pkg.sv
`default_nettype none
package vppt_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int SQRT_STEPS = 32;
  localparam int CFG_AW = 3;

  localparam logic [1:0] CMD_FWD = 2'd0;
  localparam logic [1:0] CMD_BWD = 2'd1;
  localparam logic [1:0] CMD_ROT = 2'd2;

  localparam logic [0:0] REG_DIST = 1'b0;
  localparam logic [30:0] DIST_RST = 31'd6554;

  localparam logic [22:0] ATAN_TAB [32] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
    23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2,
    23'd1, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0
  };

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [26:0] AZ180 = 27'sd11796480;
  localparam logic signed [25:0] DEG180_S = 26'sd11796480;
  localparam logic signed [25:0] DEG90_S = 26'sd5898240;
  localparam logic [33:0] DEG360_U = 34'd23592960;
  localparam logic [35:0] WRAP_OFS = 36'd4329308160;
  localparam logic [36:0] RECIP360 = 37'd372828;
  localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
  localparam logic signed [39:0] S32_MIN = -40'sd2147483648;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [25:0] z;
  } rot_t;

  typedef struct packed {
    logic [33:0] u;
    logic [9:0]  q;
  } wrap_t;

  typedef struct packed {
    logic signed [25:0] z;
    logic               flip;
  } fold_t;

  typedef struct packed {
    logic signed [34:0] vx;
    logic signed [34:0] vy;
    logic signed [26:0] vz;
    logic               az_zero;
    rot_t               pr;
    logic               pflip;
    logic [63:0]        sq_v;
    logic [63:0]        sq_r;
    logic [1:0]         cmd;
    logic signed [31:0] pz;
    logic signed [31:0] yaw;
    logic [31:0]        pitch;
    logic [30:0]        vp_dist;
  } front_t;

  typedef struct packed {
    rot_t               tr;
    logic               tflip;
    logic signed [35:0] rd;
    logic signed [35:0] hd;
    logic [1:0]         cmd;
    logic [31:0]        pitch;
    logic               unreach;
  } back_t;

  function automatic rot_t cordic_rot(rot_t c, logic [4:0] i);
    rot_t n;
    n = c;
    if (c.z >= 0) begin
      n.x = c.x - (c.y >>> i);
      n.y = c.y + (c.x >>> i);
      n.z = c.z - $signed(26'(ATAN_TAB[i]));
    end else begin
      n.x = c.x + (c.y >>> i);
      n.y = c.y - (c.x >>> i);
      n.z = c.z + $signed(26'(ATAN_TAB[i]));
    end
    return n;
  endfunction

  // first half of the reduction into [-180, 180): quotient by 360 degrees
  function automatic wrap_t wrap_a(logic signed [32:0] a);
    logic [35:0] s;
    logic [36:0] p;
    wrap_t w;
    s = 36'(a) + WRAP_OFS;
    w.u = s[33:0];
    p = 37'(w.u[33:16]) * RECIP360;
    w.q = p[36:27];
    return w;
  endfunction

  function automatic fold_t wrap_b(wrap_t w);
    logic [33:0] m;
    logic [24:0] rem;
    logic signed [25:0] r;
    fold_t f;
    m = 34'(w.q) * DEG360_U;
    rem = 25'(w.u - m);
    r = $signed(26'(rem)) - DEG180_S;
    f.z = r;
    f.flip = 1'b0;
    if (r > DEG90_S) begin
      f.z = r - DEG180_S;
      f.flip = 1'b1;
    end else if (r < -DEG90_S) begin
      f.z = r + DEG180_S;
      f.flip = 1'b1;
    end
    return f;
  endfunction

  function automatic logic [31:0] sat32(logic signed [39:0] v);
    logic [31:0] o;
    o = v[31:0];
    if (v > S32_MAX) o = 32'h7fffffff;
    else if (v < S32_MIN) o = 32'h80000000;
    return o;
  endfunction

endpackage
`default_nettype wire

### sv/vppt_if.sv
`default_nettype none
interface vppt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] yaw_step_deg;
  logic signed [31:0] pitch_deg;
  modport source(output valid, cmd, pos_x, pos_y, pos_z, yaw_step_deg, pitch_deg,
                 input ready);
  modport sink(input valid, cmd, pos_x, pos_y, pos_z, yaw_step_deg, pitch_deg,
               output ready);
endinterface

interface vppt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] target_pitch;
  logic [1:0]         motion_code;
  logic               unreachable;
  modport source(output valid, target_x, target_y, target_z, target_pitch, motion_code,
                 unreachable, input ready);
  modport sink(input valid, target_x, target_y, target_z, target_pitch, motion_code,
               unreachable, output ready);
endinterface
`default_nettype wire

### sv/vppt_front_cell.sv
`default_nettype none
module vppt_front_cell import vppt_pkg::*; #(
  parameter int STEP = 0,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  front_t in_data,
  output logic   out_valid,
  output front_t out_data
);

  localparam logic [63:0] SQ_BIT = 64'(1) << (62 - 2 * STEP);
  localparam logic [4:0] IDX = 5'(STEP);

  logic   valid_r;
  front_t data_r;
  front_t data_nxt;
  logic [63:0] sq_sum;

  always_comb begin
    data_nxt = in_data;
    if (STEP < CORDIC_STEPS) begin
      if (in_data.vy > 0) begin
        data_nxt.vx = in_data.vx + (in_data.vy >>> IDX);
        data_nxt.vy = in_data.vy - (in_data.vx >>> IDX);
        data_nxt.vz = in_data.vz + $signed(27'(ATAN_TAB[IDX]));
      end else begin
        data_nxt.vx = in_data.vx - (in_data.vy >>> IDX);
        data_nxt.vy = in_data.vy + (in_data.vx >>> IDX);
        data_nxt.vz = in_data.vz - $signed(27'(ATAN_TAB[IDX]));
      end
      data_nxt.pr = cordic_rot(in_data.pr, IDX);
    end
    sq_sum = in_data.sq_r + SQ_BIT;
    if (in_data.sq_v >= sq_sum) begin
      data_nxt.sq_v = in_data.sq_v - sq_sum;
      data_nxt.sq_r = (in_data.sq_r >> 1) + SQ_BIT;
    end else begin
      data_nxt.sq_r = in_data.sq_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data = data_r;

endmodule
`default_nettype wire

### sv/vppt_back_cell.sv
`default_nettype none
module vppt_back_cell import vppt_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  back_t in_data,
  output logic  out_valid,
  output back_t out_data
);

  localparam logic [4:0] IDX = 5'(STEP);

  logic  valid_r;
  back_t data_r;
  back_t data_nxt;

  always_comb begin
    data_nxt = in_data;
    data_nxt.tr = cordic_rot(in_data.tr, IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data = data_r;

endmodule
`default_nettype wire

### sv/virtual_point_pose_target.sv
// virtual point pose target
// in_ch carries one move transaction (forward, backward or rotate) with the tool
// position and two angles; out_ch returns one target pose transaction for each,
// in order. A transaction with cmd 3 is taken and dropped without a result.
// The distance register sits behind the apb port at address 0 and resets to
// 6554 (0.1 m); write it only while no transaction is in flight.
// One transaction is taken every cycle unless out_ch stalls: two chains of
// registered cells do the work, 32 cells for azimuth, pitch sine/cosine and
// the radius square root, then CORDIC_STEPS cells for the target rotation.
// The whole pipeline advances together: while out_ch holds a result that the
// receiver does not take, every stage and in_ch.ready hold.
// Reset clears all stage valid bits and the output valid; the distance
// register returns to its reset value.
`default_nettype none
module virtual_point_pose_target import vppt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  vppt_in_if.sink           in_ch,
  vppt_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic en;
  logic [30:0] dist_r;

  // stage 0
  logic v0_r;
  logic [1:0] c0_r;
  logic signed [31:0] px0_r, py0_r, pz0_r, yaw0_r;
  logic [31:0] pit0_r;
  logic [30:0] d0_r;
  logic cmd_ok;

  // stage 1
  logic v1_r;
  logic signed [34:0] vx1_r, vy1_r, vx1_nxt, vy1_nxt;
  logic signed [26:0] vz1_r, vz1_nxt;
  logic az0_1_r;
  logic [63:0] sqx1_r, sqy1_r;
  wrap_t pw1_r;
  logic [1:0] c1_r;
  logic signed [31:0] pz1_r, yaw1_r;
  logic [31:0] pit1_r;
  logic [30:0] d1_r;

  // front chain
  logic   fv [SQRT_STEPS+1];
  front_t fd [SQRT_STEPS+1];
  logic   fv0_r;
  front_t fd0_r, fd0_nxt;
  fold_t  pfold;

  // stage 3
  logic v3_r;
  logic signed [65:0] ps3_r, pc3_r;
  logic signed [33:0] sp3, cp3;
  logic signed [26:0] az3;
  logic signed [32:0] ta3;
  wrap_t tw3_r;
  logic [32:0] r3_r;
  logic [1:0] c3_r;
  logic signed [31:0] pz3_r;
  logic [31:0] pit3_r;

  // back chain
  logic  bv [CORDIC_STEPS+1];
  back_t bd [CORDIC_STEPS+1];
  logic  bv0_r;
  back_t bd0_r, bd0_nxt;
  fold_t tfold;
  logic signed [35:0] dsin4, dcos4, r4, pz4;

  // stage 5
  logic v5_r;
  logic signed [69:0] mx5_r, my5_r;
  logic signed [33:0] ct5, st5;
  logic signed [35:0] hd5_r;
  logic [1:0] c5_r;
  logic [31:0] pit5_r;
  logic un5_r;

  // output stage
  logic ov_r;
  logic [31:0] tx_r, ty_r, tz_r, tp_r;
  logic [1:0] mc_r;
  logic un_r;

  assign en = !ov_r || out_ch.ready;
  assign in_ch.ready = en;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1:2] == REG_DIST) ? {1'b0, dist_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= DIST_RST;
    end else if (psel && penable && pwrite && paddr[CFG_AW-1:2] == REG_DIST) begin
      dist_r <= pwdata[30:0];
    end
  end

  // stage 0: input register
  assign cmd_ok = (in_ch.cmd == CMD_FWD) || (in_ch.cmd == CMD_BWD) ||
                  (in_ch.cmd == CMD_ROT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid && cmd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r   <= in_ch.cmd;
      px0_r  <= in_ch.pos_x;
      py0_r  <= in_ch.pos_y;
      pz0_r  <= in_ch.pos_z;
      yaw0_r <= in_ch.yaw_step_deg;
      pit0_r <= in_ch.pitch_deg;
      d0_r   <= dist_r;
    end
  end

  // stage 1: left half-plane fold, squares, pitch range reduction
  always_comb begin
    if (px0_r < 0) begin
      vx1_nxt = -35'(px0_r);
      vy1_nxt = -35'(py0_r);
      vz1_nxt = (py0_r >= 0) ? AZ180 : -AZ180;
    end else begin
      vx1_nxt = 35'(px0_r);
      vy1_nxt = 35'(py0_r);
      vz1_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx1_r   <= vx1_nxt;
      vy1_r   <= vy1_nxt;
      vz1_r   <= vz1_nxt;
      az0_1_r <= (px0_r == 0) && (py0_r == 0);
      sqx1_r  <= 64'(px0_r * px0_r);
      sqy1_r  <= 64'(py0_r * py0_r);
      pw1_r   <= wrap_a(33'($signed(pit0_r)));
      c1_r    <= c0_r;
      pz1_r   <= pz0_r;
      yaw1_r  <= yaw0_r;
      pit1_r  <= pit0_r;
      d1_r    <= d0_r;
    end
  end

  // stage 2: front chain entry
  always_comb begin
    pfold = wrap_b(pw1_r);
    fd0_nxt.vx      = vx1_r;
    fd0_nxt.vy      = vy1_r;
    fd0_nxt.vz      = vz1_r;
    fd0_nxt.az_zero = az0_1_r;
    fd0_nxt.pr.x    = GAIN_Q30;
    fd0_nxt.pr.y    = '0;
    fd0_nxt.pr.z    = pfold.z;
    fd0_nxt.pflip   = pfold.flip;
    fd0_nxt.sq_v    = sqx1_r + sqy1_r;
    fd0_nxt.sq_r    = '0;
    fd0_nxt.cmd     = c1_r;
    fd0_nxt.pz      = pz1_r;
    fd0_nxt.yaw     = yaw1_r;
    fd0_nxt.pitch   = pit1_r;
    fd0_nxt.vp_dist = d1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv0_r <= 1'b0;
    end else if (en) begin
      fv0_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fd0_r <= fd0_nxt;
    end
  end

  assign fv[0] = fv0_r;
  assign fd[0] = fd0_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_front
    vppt_front_cell #(
      .STEP(k),
      .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .en(en),
      .in_valid(fv[k]),
      .in_data(fd[k]),
      .out_valid(fv[k+1]),
      .out_data(fd[k+1])
    );
  end

  // stage 3: distance products, target angle reduction
  always_comb begin
    sp3 = fd[SQRT_STEPS].pflip ? -fd[SQRT_STEPS].pr.y : fd[SQRT_STEPS].pr.y;
    cp3 = fd[SQRT_STEPS].pflip ? -fd[SQRT_STEPS].pr.x : fd[SQRT_STEPS].pr.x;
    az3 = fd[SQRT_STEPS].az_zero ? '0 : fd[SQRT_STEPS].vz;
    ta3 = 33'(az3) - 33'(fd[SQRT_STEPS].yaw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= fv[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps3_r  <= $signed({1'b0, fd[SQRT_STEPS].vp_dist}) * sp3;
      pc3_r  <= $signed({1'b0, fd[SQRT_STEPS].vp_dist}) * cp3;
      tw3_r  <= wrap_a(ta3);
      r3_r   <= fd[SQRT_STEPS].sq_r[32:0];
      c3_r   <= fd[SQRT_STEPS].cmd;
      pz3_r  <= fd[SQRT_STEPS].pz;
      pit3_r <= fd[SQRT_STEPS].pitch;
    end
  end

  // stage 4: new radius and height, back chain entry
  always_comb begin
    tfold = wrap_b(tw3_r);
    dsin4 = 36'(ps3_r >>> 30);
    dcos4 = 36'(pc3_r >>> 30);
    r4    = $signed(36'(r3_r));
    pz4   = 36'(pz3_r);
    bd0_nxt.tr.x  = GAIN_Q30;
    bd0_nxt.tr.y  = '0;
    bd0_nxt.tr.z  = tfold.z;
    bd0_nxt.tflip = tfold.flip;
    bd0_nxt.cmd   = c3_r;
    bd0_nxt.pitch = pit3_r;
    case (c3_r)
      CMD_FWD: begin
        bd0_nxt.rd = r4 + dsin4;
        bd0_nxt.hd = pz4 + dcos4;
      end
      CMD_BWD: begin
        bd0_nxt.rd = r4 - dsin4;
        bd0_nxt.hd = pz4 - dcos4;
      end
      default: begin
        bd0_nxt.rd = r4;
        bd0_nxt.hd = pz4;
      end
    endcase
    bd0_nxt.unreach = (c3_r == CMD_BWD) && (bd0_nxt.rd <= 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv0_r <= 1'b0;
    end else if (en) begin
      bv0_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bd0_r <= bd0_nxt;
    end
  end

  assign bv[0] = bv0_r;
  assign bd[0] = bd0_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_back
    vppt_back_cell #(
      .STEP(k)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .en(en),
      .in_valid(bv[k]),
      .in_data(bd[k]),
      .out_valid(bv[k+1]),
      .out_data(bd[k+1])
    );
  end

  // stage 5: project radius onto the target direction
  always_comb begin
    ct5 = bd[CORDIC_STEPS].tflip ? -bd[CORDIC_STEPS].tr.x : bd[CORDIC_STEPS].tr.x;
    st5 = bd[CORDIC_STEPS].tflip ? -bd[CORDIC_STEPS].tr.y : bd[CORDIC_STEPS].tr.y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= bv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx5_r  <= bd[CORDIC_STEPS].rd * ct5;
      my5_r  <= bd[CORDIC_STEPS].rd * st5;
      hd5_r  <= bd[CORDIC_STEPS].hd;
      c5_r   <= bd[CORDIC_STEPS].cmd;
      pit5_r <= bd[CORDIC_STEPS].pitch;
      un5_r  <= bd[CORDIC_STEPS].unreach;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mc_r <= c5_r;
      un_r <= un5_r;
      if (un5_r) begin
        tx_r <= '0;
        ty_r <= '0;
        tz_r <= '0;
        tp_r <= '0;
      end else begin
        tx_r <= sat32(40'(mx5_r >>> 30));
        ty_r <= sat32(40'(my5_r >>> 30));
        tz_r <= sat32(40'(hd5_r));
        tp_r <= pit5_r;
      end
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.target_x     = tx_r;
  assign out_ch.target_y     = ty_r;
  assign out_ch.target_z     = tz_r;
  assign out_ch.target_pitch = tp_r;
  assign out_ch.motion_code  = mc_r;
  assign out_ch.unreachable  = un_r;

endmodule
`default_nettype wire
